### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IBFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IBFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/ibfr_pkg.sv
`timescale 1ns / 1ps

package ibfr_pkg;

  localparam int FRAME_BYTES    = 32;
  localparam int BASIC_CHANNELS = 14;
  localparam int TOTAL_CHANNELS = 18;
  localparam int FIRST_PAIR     = 2;
  // two reads per basic channel, three per extended channel
  localparam int EMIT_OPS = 2 * BASIC_CHANNELS + 3 * (TOTAL_CHANNELS - BASIC_CHANNELS);

  localparam logic [15:0] CHK_SEED = 16'hFFFF;
  localparam logic [15:0] GAP_RST  = 16'd500;
  localparam logic [4:0]  TEL_RST  = 5'd4;

  // register indexes
  localparam logic REG_GAP = 1'b0;
  localparam logic REG_TEL = 1'b1;

  // emission step kinds
  localparam logic [2:0] OP_BLO = 3'd0;  // basic low byte
  localparam logic [2:0] OP_BHI = 3'd1;  // basic high nibble, emits
  localparam logic [2:0] OP_XN0 = 3'd2;  // extended nibble 0
  localparam logic [2:0] OP_XN1 = 3'd3;  // extended nibble 1
  localparam logic [2:0] OP_XN2 = 3'd4;  // extended nibble 2, emits

  typedef struct packed {
    logic [4:0] addr;
    logic [2:0] kind;
    logic [4:0] ch;
  } emit_op_t;

  typedef struct packed {
    logic       intake;
    logic       rd_en;
    logic [4:0] rd_addr;
    logic       rd_chk;
    logic       emit_step;
    logic [2:0] emit_kind;
    logic [4:0] emit_ch;
  } cmd_t;

  typedef struct packed {
    logic       frame_go;
    logic [4:0] len_m1;
    logic       chk_ok;
    logic       out_busy;
  } stat_t;

  // Read schedule for decoding: buffer address, step kind and channel per step.
  function automatic emit_op_t emit_op(input logic [5:0] e);
    emit_op_t   op;
    logic [5:0] j;
    logic [5:0] grp;
    logic [5:0] rem;
    op  = '0;
    j   = e - 6'(2 * BASIC_CHANNELS);
    grp = 6'd0;
    if (j >= 6'd9) begin
      grp = 6'd3;
    end else if (j >= 6'd6) begin
      grp = 6'd2;
    end else if (j >= 6'd3) begin
      grp = 6'd1;
    end
    rem = 6'(j - grp * 6'd3);
    if (e < 6'(2 * BASIC_CHANNELS)) begin
      op.addr = 5'(FIRST_PAIR + int'(e));
      op.kind = e[0] ? OP_BHI : OP_BLO;
      op.ch   = 5'(e >> 1);
    end else begin
      op.addr = 5'(FIRST_PAIR + 1 + 6 * int'(grp) + 2 * int'(rem));
      op.kind = (rem == 6'd0) ? OP_XN0 : ((rem == 6'd1) ? OP_XN1 : OP_XN2);
      op.ch   = 5'(BASIC_CHANNELS + int'(grp));
    end
    return op;
  endfunction

endpackage

### design/ibfr_dp.sv
`timescale 1ns / 1ps

module ibfr_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [39:0]      in_tdata,
  input  logic [15:0]      frame_gap,
  input  logic [4:0]       tel_len,
  input  ibfr_pkg::cmd_t   cmd,
  output ibfr_pkg::stat_t  st,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [23:0]      out_tdata,
  output logic             out_tlast
);

  logic [7:0]  mem [ibfr_pkg::FRAME_BYTES];
  logic [ibfr_pkg::FRAME_BYTES-1:0] vld_r;

  logic [31:0] last_time_r;
  logic [4:0]  pos_r, pos_nxt, pos_eff;
  logic [5:0]  fl_r, fl_nxt, fl_eff;

  logic [7:0]  byte_w;
  logic [31:0] now_w, gap_w;
  logic        take, gap_hit, is_start, len_ok, drop, done;

  logic [7:0]  rdata_r;
  logic        chk_dv_r;
  logic [4:0]  chk_idx_r;
  logic [15:0] sum_r;
  logic [7:0]  lo_r;

  logic [7:0]  acc_r;
  logic        emit_fire;
  logic [11:0] value_w;
  logic        out_valid_r, out_last_r;
  logic [4:0]  out_idx_r;
  logic [11:0] out_val_r;

  // byte intake
  assign byte_w   = in_tdata[7:0];
  assign now_w    = in_tdata[39:8];
  assign take     = in_tvalid && cmd.intake;
  assign gap_w    = now_w - last_time_r;
  assign gap_hit  = gap_w > {16'd0, frame_gap};
  assign pos_eff  = gap_hit ? 5'd0 : pos_r;
  assign is_start = (pos_eff == 5'd0);
  assign len_ok   = (byte_w == {3'd0, tel_len}) || (byte_w == 8'(ibfr_pkg::FRAME_BYTES));
  assign drop     = is_start && !len_ok;
  assign fl_eff   = is_start ? byte_w[5:0] : fl_r;
  assign done     = !drop && (fl_eff != 6'd0) && ({1'b0, pos_eff} == fl_eff - 6'd1);
  assign pos_nxt  = drop ? pos_eff : (done ? 5'd0 : pos_eff + 5'd1);
  assign fl_nxt   = drop ? fl_r : fl_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      pos_r       <= '0;
      fl_r        <= '0;
      vld_r       <= '0;
    end else if (take) begin
      last_time_r <= now_w;
      pos_r       <= pos_nxt;
      fl_r        <= fl_nxt;
      if (!drop) begin
        vld_r[pos_eff] <= 1'b1;
      end
    end
  end

  // frame buffer, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (take && !drop) begin
      mem[pos_eff] <= byte_w;
    end
    if (cmd.rd_en) begin
      rdata_r <= vld_r[cmd.rd_addr] ? mem[cmd.rd_addr] : 8'd0;
    end
  end

  // checksum accumulate, one byte per cycle behind the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_dv_r <= 1'b0;
    end else begin
      chk_dv_r <= cmd.rd_en && cmd.rd_chk;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= cmd.rd_addr;
    if (take && st.frame_go) begin
      sum_r <= ibfr_pkg::CHK_SEED;
    end else if (chk_dv_r) begin
      if ({1'b0, chk_idx_r} < fl_r - 6'd2) begin
        sum_r <= sum_r - {8'd0, rdata_r};
      end else if ({1'b0, chk_idx_r} == fl_r - 6'd2) begin
        lo_r <= rdata_r;
      end
    end
  end

  // channel assembly
  assign emit_fire = cmd.emit_step &&
                     (cmd.emit_kind == ibfr_pkg::OP_BHI || cmd.emit_kind == ibfr_pkg::OP_XN2);

  always_comb begin
    case (cmd.emit_kind)
      ibfr_pkg::OP_BHI: value_w = {rdata_r[3:0], acc_r};
      default:          value_w = {rdata_r[7:4], acc_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      case (cmd.emit_kind)
        ibfr_pkg::OP_BLO: acc_r      <= rdata_r;
        ibfr_pkg::OP_XN0: acc_r[3:0] <= rdata_r[7:4];
        ibfr_pkg::OP_XN1: acc_r[7:4] <= rdata_r[7:4];
        default:          acc_r      <= acc_r;
      endcase
    end
    if (emit_fire) begin
      out_idx_r  <= cmd.emit_ch;
      out_val_r  <= value_w;
      out_last_r <= (cmd.emit_ch == 5'(ibfr_pkg::TOTAL_CHANNELS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;

  assign st.frame_go = done && (fl_eff >= 6'd3);
  assign st.len_m1   = 5'(fl_r - 6'd1);
  assign st.chk_ok   = (sum_r[15:8] == rdata_r) && (sum_r[7:0] == lo_r);
  assign st.out_busy = out_valid_r && !out_tready;

endmodule

### design/ibfr_ctrl.sv
`timescale 1ns / 1ps

module ibfr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  ibfr_pkg::stat_t  st,
  output ibfr_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHK    = 3'd1;
  localparam logic [2:0] S_CHKEND = 3'd2;
  localparam logic [2:0] S_EISS   = 3'd3;
  localparam logic [2:0] S_EDAT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  ibfr_pkg::emit_op_t op_w;
  logic       op_emits;

  assign op_w     = ibfr_pkg::emit_op(cnt_r);
  assign op_emits = (op_w.kind == ibfr_pkg::OP_BHI) || (op_w.kind == ibfr_pkg::OP_XN2);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.intake = 1'b1;
        if (in_tvalid && st.frame_go) begin
          state_nxt = S_CHK;
          cnt_nxt   = 6'd0;
        end
      end
      S_CHK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_chk  = 1'b1;
        cmd.rd_addr = cnt_r[4:0];
        if (cnt_r[4:0] == st.len_m1) begin
          state_nxt = S_CHKEND;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_CHKEND: begin
        cnt_nxt   = 6'd0;
        state_nxt = st.chk_ok ? S_EISS : S_IDLE;
      end
      S_EISS: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = op_w.addr;
        state_nxt   = S_EDAT;
      end
      S_EDAT: begin
        cmd.emit_kind = op_w.kind;
        cmd.emit_ch   = op_w.ch;
        if (!(op_emits && st.out_busy)) begin
          cmd.emit_step = 1'b1;
          if (cnt_r == 6'(ibfr_pkg::EMIT_OPS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 6'd1;
            state_nxt = S_EISS;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### design/ibus_frame_receiver.sv
`timescale 1ns / 1ps
// Serial RC frame receiver. Each input request carries one received byte and its
// 32-bit microsecond arrival time. A gap above frame_gap_us since the previous byte
// restarts framing. A frame opens with its length byte, which must equal either
// telemetry_length or 32; other opening bytes are dropped. Bytes go into a 32-entry
// buffer that starts all zero after reset and is never cleared between frames, so a
// short frame decodes stale bytes past its end. On the last byte the checksum
// (0xFFFF minus all bytes but the last two) is checked against the last two bytes,
// low byte first; on a match 18 result requests follow: 14 twelve-bit channels from
// byte pairs at byte 2 onward, then 4 channels built from high nibbles, the last one
// marked with tlast. A byte that does not end a frame leaves the input open for the
// next byte. A byte that ends a frame of at least 3 bytes holds the input while the
// checksum walks the buffer one byte per cycle over its single read port; a failing
// frame then reopens the input, and a passing one holds it further while decoding
// reads each of 40 buffer entries in S_EISS and uses it in S_EDAT, waiting there
// when a channel is due while the output side stalls. The output register lets the
// next byte be taken while the final channel is still waiting.
// Registers (APB, 4-byte stride): 0x0 frame_gap_us [15:0] reset 500,
// 0x4 telemetry_length [4:0] reset 4.

`include "assert_macros.svh"

module ibus_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] rx_byte, [39:8] time_us
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [4:0] channel_index, [16:5] channel_value, rest zero
  output logic        out_tlast,  // last_channel
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ibfr_pkg::cmd_t  cmd;
  ibfr_pkg::stat_t st;

  logic [15:0] frame_gap_r;
  logic [4:0]  tel_len_r;
  logic        cfg_wr;

  // config registers; the low address bits are ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_gap_r <= ibfr_pkg::GAP_RST;
      tel_len_r   <= ibfr_pkg::TEL_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        ibfr_pkg::REG_GAP: frame_gap_r <= cfg_pwdata[15:0];
        ibfr_pkg::REG_TEL: tel_len_r   <= cfg_pwdata[4:0];
        default: begin
          frame_gap_r <= frame_gap_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      ibfr_pkg::REG_GAP: cfg_prdata = {16'd0, frame_gap_r};
      ibfr_pkg::REG_TEL: cfg_prdata = {27'd0, tel_len_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // input is taken only while the sequencer is idle
  assign in_tready = cmd.intake;

  ibfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .st        (st),
    .cmd       (cmd)
  );

  ibfr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .frame_gap  (frame_gap_r),
    .tel_len    (tel_len_r),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // buffer reads never overlap byte intake
  `IBFR_ASSERT_IMP(a_rd_excl_intake, cmd.rd_en, !cmd.intake, "buffer read while taking bytes")
  // a decoded channel never overwrites a result still held
  `IBFR_ASSERT_IMP(a_no_overwrite, cmd.emit_step && (cmd.emit_kind == ibfr_pkg::OP_BHI || cmd.emit_kind == ibfr_pkg::OP_XN2), !st.out_busy, "result overwritten")
  // tlast only on the final channel
  `IBFR_ASSERT_IMP(a_last_index, out_tvalid && out_tlast, out_tdata[4:0] == 5'(ibfr_pkg::TOTAL_CHANNELS - 1), "tlast on wrong channel")
  // a completed frame stops intake for the checksum walk
  `IBFR_ASSERT_NXT(a_busy_after_frame, in_tvalid && in_tready && st.frame_go, !in_tready, "intake open after frame end")

endmodule
